// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the front and level modules of the pixel converter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Property must hold at every clock edge outside reset.
`define HGC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Condition must never be true at a clock edge outside reset.
`define HGC_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define HGC_ASSERT(label, prop, msg)
`define HGC_NEVER(label, cond, msg)
`endif
`endif

// ===== rtl/hgc_pkg.sv =====
// Package with widths, constants, stage payload types and helper functions.
`default_nettype none
package hgc_pkg;

  localparam int HUE_W  = 16;
  localparam int PCT_W  = 7;
  localparam int LVL_W  = 8;
  localparam int HMOD_W = 9;
  localparam int FRAC_W = 6;
  localparam int QUO_W  = 8;
  localparam int PRODB_W = 15;
  localparam int PRODR_W = 14;

  localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;
  localparam int HUE_TURN   = 360;
  localparam int HUE_SECTOR = 60;

  // Reciprocals for exact floor division by constants over the value ranges used here.
  localparam logic [15:0] RECIP_360 = 16'd46604;  // (x * RECIP_360) >> 24, x < 65536
  localparam logic [13:0] RECIP_100 = 14'd10486;  // (x * RECIP_100) >> 20, x <= 25500
  localparam logic [14:0] RECIP_60  = 15'd17477;  // (x * RECIP_60) >> 20, x <= 15045

  typedef enum logic [2:0] {
    SEC_RED_YEL = 3'd0,
    SEC_YEL_GRN = 3'd1,
    SEC_GRN_CYN = 3'd2,
    SEC_CYN_BLU = 3'd3,
    SEC_BLU_MAG = 3'd4,
    SEC_MAG_RED = 3'd5
  } sector_t;

  typedef struct packed {
    logic [HUE_W-1:0]   hue;
    logic [QUO_W-1:0]   quo;
    logic [PCT_W-1:0]   sat;
    logic [PRODB_W-1:0] v255;
  } s1_t;

  typedef struct packed {
    logic [HMOD_W-1:0] hmod;
    logic [PCT_W-1:0]  sat;
    logic [LVL_W-1:0]  top;
  } s2_t;

  typedef struct packed {
    logic [LVL_W-1:0]   top;
    logic [PRODB_W-1:0] prod_b;
    sector_t            sector;
    logic [FRAC_W-1:0]  frac;
  } s3_t;

  typedef struct packed {
    logic [LVL_W-1:0]  top;
    logic [LVL_W-1:0]  bottom;
    sector_t           sector;
    logic [FRAC_W-1:0] frac;
  } s4_t;

  typedef struct packed {
    logic [LVL_W-1:0]   top;
    logic [LVL_W-1:0]   bottom;
    sector_t            sector;
    logic [PRODR_W-1:0] prod_r;
  } s5_t;

  typedef struct packed {
    logic [LVL_W-1:0] green;
    logic [LVL_W-1:0] red;
    logic [LVL_W-1:0] blue;
  } grb_t;

  function automatic logic [PCT_W-1:0] clamp_pct(input logic [PCT_W-1:0] p);
    return (p > PCT_FULL) ? PCT_FULL : p;
  endfunction

  function automatic logic [LVL_W-1:0] div100(input logic [PRODB_W-1:0] x);
    logic [28:0] p;
    p = 29'(x) * 29'(RECIP_100);
    return p[27:20];
  endfunction

  function automatic logic [LVL_W-1:0] div60(input logic [PRODR_W-1:0] x);
    logic [28:0] p;
    p = 29'(x) * 29'(RECIP_60);
    return p[27:20];
  endfunction

endpackage
`default_nettype wire

// ===== rtl/hgc_hsv_if.sv =====
// Input channel interface: one HSV colour per transaction.
`default_nettype none
interface hgc_hsv_if;
  import hgc_pkg::*;
  logic             valid;
  logic             ready;
  logic [HUE_W-1:0] hue;
  logic [PCT_W-1:0] saturation;
  logic [PCT_W-1:0] brightness;
  modport source (output valid, output hue, output saturation, output brightness,
                  input ready);
  modport sink   (input valid, input hue, input saturation, input brightness,
                  output ready);
endinterface
`default_nettype wire

// ===== rtl/hgc_grb_if.sv =====
// Result channel interface: one green, red, blue byte triple per transaction.
`default_nettype none
interface hgc_grb_if;
  import hgc_pkg::*;
  logic             valid;
  logic             ready;
  logic [LVL_W-1:0] green;
  logic [LVL_W-1:0] red;
  logic [LVL_W-1:0] blue;
  modport source (output valid, output green, output red, output blue, input ready);
  modport sink   (input valid, input green, input red, input blue, output ready);
endinterface
`default_nettype wire

// ===== rtl/hgc_front.sv =====
// Stages one and two: hue reduction modulo 360, percent clamping and the top level.
`default_nettype none
`include "assert_macros.svh"
module hgc_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           up_valid,
  output logic                           up_ready,
  input  logic [hgc_pkg::HUE_W-1:0]      up_hue,
  input  logic [hgc_pkg::PCT_W-1:0]      up_sat,
  input  logic [hgc_pkg::PCT_W-1:0]      up_val,
  output logic                           dn_valid,
  input  logic                           dn_ready,
  output hgc_pkg::s2_t                   dn_data
);
  import hgc_pkg::*;

  logic v1_r, v2_r;
  logic rdy1, rdy2;
  s1_t  s1_r, s1_nxt;
  s2_t  s2_r, s2_nxt;
  logic [31:0]        qprod;
  logic [PCT_W-1:0]   val_c;
  logic [HUE_W:0]     hm_full;

  assign rdy2     = !v2_r || dn_ready;
  assign rdy1     = !v1_r || rdy2;
  assign up_ready = rdy1;
  assign dn_valid = v2_r;
  assign dn_data  = s2_r;

  // Stage one: quotient of hue by 360 through its reciprocal, v * 255 by shift and subtract.
  always_comb begin
    qprod        = 32'(up_hue) * 32'(RECIP_360);
    val_c        = clamp_pct(up_val);
    s1_nxt.hue   = up_hue;
    s1_nxt.quo   = qprod[31:24];
    s1_nxt.sat   = clamp_pct(up_sat);
    s1_nxt.v255  = {val_c, 8'b0} - PRODB_W'(val_c);
  end

  // Stage two: remainder of the hue and the top level.
  always_comb begin
    hm_full     = {1'b0, s1_r.hue} - (17'(s1_r.quo) * 17'(HUE_TURN));
    s2_nxt.hmod = hm_full[HMOD_W-1:0];
    s2_nxt.sat  = s1_r.sat;
    s2_nxt.top  = div100(s1_r.v255);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= up_valid;
      if (rdy2) v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && up_valid) s1_r <= s1_nxt;
    if (rdy2 && v1_r) s2_r <= s2_nxt;
  end

  `HGC_ASSERT(a_hmod_range, v2_r |-> (s2_r.hmod < 9'(HUE_TURN)), "hue remainder out of range")
  `HGC_ASSERT(a_top_range, v2_r |-> (s2_r.top <= 8'd255 && s2_r.sat <= PCT_FULL),
              "stage two levels out of range")

endmodule
`default_nettype wire

// ===== rtl/hgc_level.sv =====
// Stages three and four: sector split, bottom level product and division.
`default_nettype none
`include "assert_macros.svh"
module hgc_level (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         up_valid,
  output logic         up_ready,
  input  hgc_pkg::s2_t up_data,
  output logic         dn_valid,
  input  logic         dn_ready,
  output hgc_pkg::s4_t dn_data
);
  import hgc_pkg::*;

  logic v3_r, v4_r;
  logic rdy3, rdy4;
  s3_t  s3_r, s3_nxt;
  s4_t  s4_r, s4_nxt;
  logic [HMOD_W-1:0] base;
  sector_t           sec;

  assign rdy4     = !v4_r || dn_ready;
  assign rdy3     = !v3_r || rdy4;
  assign up_ready = rdy3;
  assign dn_valid = v4_r;
  assign dn_data  = s4_r;

  // Stage three: sector by comparing against the sector bounds, and top * (100 - s).
  always_comb begin
    if (up_data.hmod < 9'(HUE_SECTOR)) begin
      sec = SEC_RED_YEL; base = 9'd0;
    end else if (up_data.hmod < 9'(2 * HUE_SECTOR)) begin
      sec = SEC_YEL_GRN; base = 9'(HUE_SECTOR);
    end else if (up_data.hmod < 9'(3 * HUE_SECTOR)) begin
      sec = SEC_GRN_CYN; base = 9'(2 * HUE_SECTOR);
    end else if (up_data.hmod < 9'(4 * HUE_SECTOR)) begin
      sec = SEC_CYN_BLU; base = 9'(3 * HUE_SECTOR);
    end else if (up_data.hmod < 9'(5 * HUE_SECTOR)) begin
      sec = SEC_BLU_MAG; base = 9'(4 * HUE_SECTOR);
    end else begin
      sec = SEC_MAG_RED; base = 9'(5 * HUE_SECTOR);
    end
    s3_nxt.top    = up_data.top;
    s3_nxt.prod_b = PRODB_W'(up_data.top) * PRODB_W'(PCT_FULL - up_data.sat);
    s3_nxt.sector = sec;
    s3_nxt.frac   = FRAC_W'(up_data.hmod - base);
  end

  // Stage four: bottom level.
  always_comb begin
    s4_nxt.top    = s3_r.top;
    s4_nxt.bottom = div100(s3_r.prod_b);
    s4_nxt.sector = s3_r.sector;
    s4_nxt.frac   = s3_r.frac;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (rdy3) v3_r <= up_valid;
      if (rdy4) v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3 && up_valid) s3_r <= s3_nxt;
    if (rdy4 && v3_r) s4_r <= s4_nxt;
  end

  `HGC_ASSERT(a_bottom_le_top, v4_r |-> (s4_r.bottom <= s4_r.top), "bottom above top")
  `HGC_ASSERT(a_frac_range, v4_r |-> (s4_r.frac < 6'(HUE_SECTOR)), "hue offset out of range")
  `HGC_ASSERT(a_stall_keeps, (v4_r && !dn_ready) |=> (v4_r && $stable(s4_r)),
              "stalled stage four lost its transaction")

endmodule
`default_nettype wire

// ===== rtl/hgc_mix.sv =====
// Stages five and six: ramp product, ramp division and the per-sector channel mux.
`default_nettype none
module hgc_mix (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         up_valid,
  output logic         up_ready,
  input  hgc_pkg::s4_t up_data,
  output logic         dn_valid,
  input  logic         dn_ready,
  output hgc_pkg::grb_t dn_data
);
  import hgc_pkg::*;

  logic v5_r, v6_r;
  logic rdy5, rdy6;
  s5_t  s5_r, s5_nxt;
  grb_t out_r, out_nxt;
  logic [LVL_W-1:0] ramp, up, down, top, bot;

  assign rdy6     = !v6_r || dn_ready;
  assign rdy5     = !v5_r || rdy6;
  assign up_ready = rdy5;
  assign dn_valid = v6_r;
  assign dn_data  = out_r;

  always_comb begin
    s5_nxt.top    = up_data.top;
    s5_nxt.bottom = up_data.bottom;
    s5_nxt.sector = up_data.sector;
    s5_nxt.prod_r = PRODR_W'(up_data.top - up_data.bottom) * PRODR_W'(up_data.frac);
  end

  always_comb begin
    top  = s5_r.top;
    bot  = s5_r.bottom;
    ramp = div60(s5_r.prod_r);
    up   = bot + ramp;
    down = top - ramp;
    case (s5_r.sector)
      SEC_RED_YEL: begin out_nxt.red = top;  out_nxt.green = up;   out_nxt.blue = bot;  end
      SEC_YEL_GRN: begin out_nxt.red = down; out_nxt.green = top;  out_nxt.blue = bot;  end
      SEC_GRN_CYN: begin out_nxt.red = bot;  out_nxt.green = top;  out_nxt.blue = up;   end
      SEC_CYN_BLU: begin out_nxt.red = bot;  out_nxt.green = down; out_nxt.blue = top;  end
      SEC_BLU_MAG: begin out_nxt.red = up;   out_nxt.green = bot;  out_nxt.blue = top;  end
      default:     begin out_nxt.red = top;  out_nxt.green = bot;  out_nxt.blue = down; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else begin
      if (rdy5) v5_r <= up_valid;
      if (rdy6) v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy5 && up_valid) s5_r <= s5_nxt;
    if (rdy6 && v5_r) out_r <= out_nxt;
  end

endmodule
`default_nettype wire

// ===== rtl/hsv_to_grb_pixel_convert.sv =====
// Top level of the HSV to GRB pixel converter: six-stage pipeline with handshakes.
//
// The input channel in_pix carries one HSV colour per transaction: a 16-bit hue
// in degrees that is reduced modulo 360, and saturation and brightness percents
// that saturate at 100. The result channel out_pix returns the green, red and
// blue bytes of that colour, in the order the LED strip expects, one result
// transaction for each input transaction and in the same order.
// The pipeline has six register stages. One pixel is accepted in every cycle
// while the receiver keeps out_pix.ready high. Each stage holds one multiplier,
// either a constant-reciprocal divide (by 360, 100, 100 and 60) or a plain
// product, and stage two also multiplies the quotient by 360; the multipliers
// set the stage depth.
// Each stage carries its own valid bit. When the receiver holds out_pix.ready
// low, the last stage keeps its result and the stages behind it close up any
// empty slots before in_pix.ready drops, so no transaction is lost or repeated.
// The synchronous reset clears all valid bits; the stage data registers are not reset.
`default_nettype none
module hsv_to_grb_pixel_convert (
  input  logic     clk,
  input  logic     rst_n,
  hgc_hsv_if.sink  in_pix,
  hgc_grb_if.source out_pix
);
  import hgc_pkg::*;

  // Handshakes between the three stage pairs.
  logic f_valid, f_ready;
  logic l_valid, l_ready;
  s2_t  f_data;
  s4_t  l_data;
  grb_t m_data;

  // Hue reduction, percent clamping and top level.
  hgc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_pix.valid),
    .up_ready (in_pix.ready),
    .up_hue   (in_pix.hue),
    .up_sat   (in_pix.saturation),
    .up_val   (in_pix.brightness),
    .dn_valid (f_valid),
    .dn_ready (f_ready),
    .dn_data  (f_data)
  );

  // Sector selection and bottom level.
  hgc_level u_level (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (f_valid),
    .up_ready (f_ready),
    .up_data  (f_data),
    .dn_valid (l_valid),
    .dn_ready (l_ready),
    .dn_data  (l_data)
  );

  // Ramp computation and the final output register.
  hgc_mix u_mix (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (l_valid),
    .up_ready (l_ready),
    .up_data  (l_data),
    .dn_valid (out_pix.valid),
    .dn_ready (out_pix.ready),
    .dn_data  (m_data)
  );

  assign out_pix.green = m_data.green;
  assign out_pix.red   = m_data.red;
  assign out_pix.blue  = m_data.blue;

endmodule
`default_nettype wire
